FILE: rtl/core/ipadl_pkg.sv
// ----------------------------------------------------------------------------
// ipadl_pkg
// Shared types and codes for the IP prefix allow/deny list.
// ----------------------------------------------------------------------------
`default_nettype none

package ipadl_pkg;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam int KEY_W = 128;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	// Item as it travels down the cell chain. The key is the address widened to
	// 128 bits (IPv4 sits in the low 32 bits). eff_len is the prefix length
	// measured from bit 127, so IPv4 prefixes are offset by 96.
	typedef struct packed {
		logic             cmd;
		logic             is_v6;
		logic [KEY_W-1:0] key;
		logic [7:0]       eff_len;
		status_t          status;
		logic             matched;
	} item_t;

endpackage

`default_nettype wire

FILE: rtl/core/ipadl_in_if.sv
// ----------------------------------------------------------------------------
// ipadl_in_if
// Request channel: insert or lookup item with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipadl_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic        is_v6;
	logic [63:0] addr_hi;
	logic [63:0] addr_lo;
	logic [7:0]  prefix_len;

	modport source (output valid, cmd, is_v6, addr_hi, addr_lo, prefix_len, input ready);
	modport sink (input valid, cmd, is_v6, addr_hi, addr_lo, prefix_len, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ipadl_out_if.sv
// ----------------------------------------------------------------------------
// ipadl_out_if
// Response channel: decision and status with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipadl_out_if;
	logic       valid;
	logic       ready;
	logic       allowed;
	logic       matched;
	logic [1:0] status;

	modport source (output valid, allowed, matched, status, input ready);
	modport sink (input valid, allowed, matched, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ipadl_head.sv
// ----------------------------------------------------------------------------
// ipadl_head
// Entry stage: normalizes the address, checks inserts, keeps the entry count
// and stamps each item with the count (slot for inserts, fill for lookups).
// ----------------------------------------------------------------------------
`default_nettype none

module ipadl_head #(
	parameter int TABLE_DEPTH = 64,
	parameter int CNT_W       = 7
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  adv,
	ipadl_in_if.sink             req,
	output logic                 vld_o,
	output ipadl_pkg::item_t     item_o,
	output logic [CNT_W-1:0]     cnt_o
);
	import ipadl_pkg::*;

	logic             count_inc;
	logic             accept;
	logic             too_long;
	logic             full;
	logic [CNT_W-1:0] count_q;
	item_t            item_d;
	item_t            item_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic             vld_s1;

	assign req.ready = adv;
	assign accept    = req.valid && adv;

	always_comb begin
		too_long = req.is_v6 ? (req.prefix_len > 8'd128) : (req.prefix_len > 8'd32);
		full     = (count_q == CNT_W'(TABLE_DEPTH));

		item_d.cmd     = req.cmd;
		item_d.is_v6   = req.is_v6;
		item_d.key     = req.is_v6 ? {req.addr_hi, req.addr_lo} : {96'd0, req.addr_lo[31:0]};
		item_d.eff_len = req.is_v6 ? req.prefix_len : req.prefix_len + 8'd96;
		item_d.matched = 1'b0;
		if (req.cmd == CMD_LOOKUP) begin
			item_d.status = ST_OK;
		end else if (too_long) begin
			item_d.status = ST_TOO_LONG;
		end else if (full) begin
			item_d.status = ST_FULL;
		end else begin
			item_d.status = ST_OK;
		end
		count_inc = accept && (req.cmd == CMD_INSERT) && (item_d.status == ST_OK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (count_inc) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (adv) begin
				vld_s1 <= req.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item_d;
			cnt_s1  <= count_q;
		end
	end

	assign vld_o  = vld_s1;
	assign item_o = item_s1;
	assign cnt_o  = cnt_s1;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		count_inc |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("good insert did not bump entry count");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.cmd == CMD_INSERT) && (too_long || full) |=> $stable(count_q))
		else $error("rejected insert changed entry count");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ipadl_cell.sv
// ----------------------------------------------------------------------------
// ipadl_cell
// One table slot. Captures the insert aimed at its slot, and ORs its match
// into each lookup passing by before handing the item to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ipadl_cell #(
	parameter int CELL_IDX = 0,
	parameter int CNT_W    = 7
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  adv,
	input  wire                  vld_i,
	input  wire ipadl_pkg::item_t item_i,
	input  wire [CNT_W-1:0]      cnt_i,
	output logic                 vld_o,
	output ipadl_pkg::item_t     item_o,
	output logic [CNT_W-1:0]     cnt_o
);
	import ipadl_pkg::*;

	logic             ver_q;
	logic [KEY_W-1:0] key_q;
	logic [7:0]       len_q;
	logic [KEY_W-1:0] mask;
	logic             wr;
	logic             used;
	logic             hit;
	item_t            item_d;
	item_t            item_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic             vld_s1;

	always_comb begin
		// bit b is part of the prefix when b >= 128 - len
		for (int b = 0; b < KEY_W; b++) begin
			mask[b] = ({1'b0, len_q} >= 9'(KEY_W - b));
		end
		wr   = adv && vld_i && (item_i.cmd == CMD_INSERT) && (item_i.status == ST_OK)
			&& (cnt_i == CNT_W'(CELL_IDX));
		used = (cnt_i > CNT_W'(CELL_IDX));
		hit  = vld_i && (item_i.cmd == CMD_LOOKUP) && used && (ver_q == item_i.is_v6)
			&& (((item_i.key ^ key_q) & mask) == '0);
		item_d         = item_i;
		item_d.matched = item_i.matched | hit;
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ver_q <= item_i.is_v6;
			key_q <= item_i.key;
			len_q <= item_i.eff_len;
		end
		if (adv) begin
			item_s1 <= item_d;
			cnt_s1  <= cnt_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
		end
	end

	assign vld_o  = vld_s1;
	assign item_o = item_s1;
	assign cnt_o  = cnt_s1;

endmodule

`default_nettype wire

FILE: rtl/core/ip_prefix_allow_deny_list.sv
// Throughput: one item per cycle while the response is not stalled; each item
// passes the entry stage, then walks the chain of TABLE_DEPTH slot cells, one
// cell per cycle, and an insert lands in its cell on the way. A stalled
// response freezes the whole chain, so input waits with it.
// Reset clears the entry count, the chain valid bits and deny_mode; the slot
// contents are not cleared and are ignored until written.
// ----------------------------------------------------------------------------
// ip_prefix_allow_deny_list
// IPv4/IPv6 prefix table with insert and lookup; decision is match XOR
// deny_mode.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_prefix_allow_deny_list #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       cfg_we,
	input  wire       cfg_wdata,
	ipadl_in_if.sink  req,
	ipadl_out_if.source rsp
);
	import ipadl_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic             adv;
	logic             deny_q;
	logic             stg_vld  [TABLE_DEPTH+1];
	item_t            stg_item [TABLE_DEPTH+1];
	logic [CNT_W-1:0] stg_cnt  [TABLE_DEPTH+1];

	assign adv = !stg_vld[TABLE_DEPTH] || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deny_q <= 1'b0;
		end else if (cfg_we) begin
			deny_q <= cfg_wdata;
		end
	end

	ipadl_head #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.CNT_W       (CNT_W)
	) u_head (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.req    (req),
		.vld_o  (stg_vld[0]),
		.item_o (stg_item[0]),
		.cnt_o  (stg_cnt[0])
	);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		ipadl_cell #(
			.CELL_IDX (i),
			.CNT_W    (CNT_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.vld_i  (stg_vld[i]),
			.item_i (stg_item[i]),
			.cnt_i  (stg_cnt[i]),
			.vld_o  (stg_vld[i+1]),
			.item_o (stg_item[i+1]),
			.cnt_o  (stg_cnt[i+1])
		);
	end

	assign rsp.valid   = stg_vld[TABLE_DEPTH];
	assign rsp.matched = stg_item[TABLE_DEPTH].matched;
	assign rsp.allowed = (stg_item[TABLE_DEPTH].cmd == CMD_LOOKUP)
		&& (stg_item[TABLE_DEPTH].matched ^ deny_q);
	assign rsp.status  = stg_item[TABLE_DEPTH].status;

`ifndef SYNTHESIS
	a_chain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stg_vld[TABLE_DEPTH] && !rsp.ready |=>
			stg_vld[TABLE_DEPTH] && $stable(stg_item[TABLE_DEPTH]))
		else $error("chain moved while response stalled");

	a_insert_nomatch: assert property (@(posedge clk) disable iff (!arst_n)
		stg_vld[TABLE_DEPTH] && (stg_item[TABLE_DEPTH].cmd == CMD_INSERT)
			|-> !stg_item[TABLE_DEPTH].matched)
		else $error("insert item picked up a match");

	a_lookup_ok: assert property (@(posedge clk) disable iff (!arst_n)
		stg_vld[TABLE_DEPTH] && (stg_item[TABLE_DEPTH].cmd == CMD_LOOKUP)
			|-> stg_item[TABLE_DEPTH].status == ST_OK)
		else $error("lookup item carries error status");
`endif

endmodule

`default_nettype wire

FILE: dv/ip_prefix_allow_deny_list_tb.sv
// ----------------------------------------------------------------------------
// ip_prefix_allow_deny_list_tb
// Drives insert and lookup items through the prefix table and checks every
// decision against a cycle-free model of the table kept in the bench. A short
// directed table comes first, then random items in three idling phases with
// deny_mode changed between phases while the block is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ip_prefix_allow_deny_list_tb;
	import ipadl_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int PHASE_ITEMS = 459;
	localparam int RAND_ITEMS  = 3 * PHASE_ITEMS;
	localparam int LATE_ITEMS  = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DIR_ROWS    = 24;
	localparam int DENY_ROW    = 2;
	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic        cmd;
		logic        is_v6;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [7:0]  plen;
	} acl_req_t;

	typedef struct packed {
		logic    allowed;
		logic    matched;
		status_t status;
	} acl_rsp_t;

	typedef struct packed {
		acl_req_t item;
		logic     fixed;
		acl_rsp_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	ipadl_in_if  req();
	ipadl_out_if rsp();

	ip_prefix_allow_deny_list #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req.sink),
		.rsp       (rsp.source)
	);

	always #5 clk = ~clk;

	// bench copy of the table and the register
	logic         deny_cfg;
	int           tbl_count;
	logic         tbl_v6  [TABLE_DEPTH];
	logic [127:0] tbl_key [TABLE_DEPTH];
	logic [7:0]   tbl_len [TABLE_DEPTH];

	acl_rsp_t decision_q[$];
	int       mismatches;
	int       src_idle = 28;
	int       snk_idle = 60;
	int       stall_reqs;
	int       stall_seen;
	int       hold_left;
	int       idle_cycles;
	dir_row_t dir_rows [DIR_ROWS];

	// leading-bits mask of a stored prefix, IPv4 living in the low 32 bits
	function automatic logic [127:0] span_mask(logic v6, logic [7:0] len);
		int eff;
		eff = v6 ? int'(len) : int'(len) + 96;
		return ~128'h0 << (128 - eff);
	endfunction

	function automatic acl_rsp_t predict_decision(acl_req_t it);
		acl_rsp_t     r;
		logic [127:0] key;
		int           maxlen;
		logic         hit;
		r = '0;
		hit = 1'b0;
		key = it.is_v6 ? {it.hi, it.lo} : {96'h0, it.lo[31:0]};
		if (it.cmd == CMD_INSERT) begin
			maxlen = it.is_v6 ? 128 : 32;
			if (int'(it.plen) > maxlen) begin
				r.status = ST_TOO_LONG;
			end else if (tbl_count >= TABLE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				tbl_v6[tbl_count] = it.is_v6;
				tbl_key[tbl_count] = key;
				tbl_len[tbl_count] = it.plen;
				tbl_count++;
			end
		end else begin
			for (int i = 0; i < tbl_count; i++) begin
				if (tbl_v6[i] == it.is_v6 &&
						((key ^ tbl_key[i]) & span_mask(tbl_v6[i], tbl_len[i])) == '0)
					hit = 1'b1;
			end
			r.matched = hit;
			r.allowed = hit ^ deny_cfg;
		end
		return r;
	endfunction

	function automatic dir_row_t mk(logic cmd, logic v6, logic [63:0] hi, logic [63:0] lo,
			logic [7:0] len, logic fixed, logic a, logic m, status_t st);
		dir_row_t row;
		row.item = '{cmd: cmd, is_v6: v6, hi: hi, lo: lo, plen: len};
		row.fixed = fixed;
		row.want = '{allowed: a, matched: m, status: st};
		return row;
	endfunction

	// Zero-length entries are held back to the tail of the run, since one of
	// them makes every later lookup of its version a hit.
	function automatic acl_req_t rand_item(int idx);
		acl_req_t     it;
		logic [127:0] mask;
		logic [127:0] key;
		int           k;
		int           pick;
		int           pos;
		logic         late;
		late = (idx >= RAND_ITEMS - LATE_ITEMS);
		pick = $urandom_range(99);
		it.cmd = CMD_LOOKUP;
		it.is_v6 = 1'($urandom_range(1));
		it.hi = {$urandom, $urandom};
		it.lo = {$urandom, $urandom};
		it.plen = 8'($urandom_range(255));
		if (late && tbl_count < TABLE_DEPTH) begin
			it.cmd = CMD_INSERT;
			it.is_v6 = tbl_count[0];
			it.plen = 8'd0;
		end else if (pick < 4) begin
			it.cmd = CMD_INSERT;
			it.plen = 8'(it.is_v6 ? $urandom_range(255, 129) : $urandom_range(255, 33));
		end else if (pick < 16 && (late || tbl_count < TABLE_DEPTH - 2)) begin
			it.cmd = CMD_INSERT;
			it.plen = 8'(it.is_v6 ? $urandom_range(128, 1) : $urandom_range(32, 1));
		end else if (tbl_count > 0 && $urandom_range(99) < 65) begin
			// aim at a stored prefix; host bits random, sometimes one prefix bit flipped
			k = $urandom_range(tbl_count - 1);
			it.is_v6 = tbl_v6[k];
			mask = span_mask(tbl_v6[k], tbl_len[k]);
			key = (tbl_key[k] & mask) | ({it.hi, it.lo} & ~mask);
			if (tbl_len[k] != 0 && $urandom_range(3) == 0) begin
				pos = (tbl_v6[k] ? 127 : 31) - int'($urandom_range(tbl_len[k] - 1));
				key = key ^ (128'h1 << pos);
			end
			if (it.is_v6)
				{it.hi, it.lo} = key;
			else
				it.lo[31:0] = key[31:0];
		end
		return it;
	endfunction

	task automatic flag(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	task automatic offer(input acl_req_t it, input logic fixed, input acl_rsp_t want);
		acl_rsp_t pred;
		while ($urandom_range(99) < src_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= it.cmd;
		req.is_v6 <= it.is_v6;
		req.addr_hi <= it.hi;
		req.addr_lo <= it.lo;
		req.prefix_len <= it.plen;
		@(posedge clk);
		while (req.ready !== 1'b1)
			@(posedge clk);
		pred = predict_decision(it);
		decision_q = {decision_q, (fixed ? want : pred)};
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		while (decision_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_deny(input logic v);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		deny_cfg = v;
	endtask

	// receiver: random ready, or a long hold when the sender asks for one
	initial rsp.ready = 1'b0;
	always @(posedge clk) begin
		if (stall_seen != stall_reqs) begin
			stall_seen <= stall_reqs;
			hold_left <= HOLD_CYCLES;
			rsp.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	always @(posedge clk) begin
		acl_rsp_t got;
		acl_rsp_t want;
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			got = '{allowed: rsp.allowed, matched: rsp.matched,
				status: status_t'(rsp.status)};
			if (decision_q.size() == 0) begin
				flag($sformatf("unexpected result: allowed %b matched %b status %0d",
					got.allowed, got.matched, got.status));
			end else begin
				want = decision_q.pop_front();
				if (got.allowed !== want.allowed || got.matched !== want.matched ||
						got.status !== want.status)
					flag($sformatf({"mismatch: allowed %b/%b matched %b/%b ",
						"status %0d/%0d (expected/actual)"}, want.allowed, got.allowed,
						want.matched, got.matched, want.status, got.status));
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid === 1'b1 && req.ready === 1'b1) ||
				(rsp.valid === 1'b1 && rsp.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("ip_prefix_allow_deny_list_tb: errors");
			$finish;
		end
	end

	initial begin
		acl_req_t it;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req.valid = 1'b0;
		req.cmd = CMD_INSERT;
		req.is_v6 = 1'b0;
		req.addr_hi = '0;
		req.addr_lo = '0;
		req.prefix_len = '0;
		deny_cfg = 1'b0;
		tbl_count = 0;
		mismatches = 0;
		stall_reqs = 0;
		stall_seen = 0;
		hold_left = 0;
		idle_cycles = 0;

		dir_rows = '{
			// empty table, allow list
			mk(CMD_LOOKUP, 1'b0, 64'h0, 64'h0, 8'd0, 1'b1, 1'b0, 1'b0, ST_OK),
			mk(CMD_LOOKUP, 1'b1, ONES, ONES, 8'hFF, 1'b1, 1'b0, 1'b0, ST_OK),
			// empty table, deny list
			mk(CMD_LOOKUP, 1'b0, ONES, ONES, 8'd0, 1'b1, 1'b1, 1'b0, ST_OK),
			mk(CMD_INSERT, 1'b0, 64'h0, 64'h0A00_0000, 8'd33, 1'b1, 1'b0, 1'b0, ST_TOO_LONG),
			mk(CMD_INSERT, 1'b1, 64'h0, 64'h0, 8'd129, 1'b1, 1'b0, 1'b0, ST_TOO_LONG),
			mk(CMD_INSERT, 1'b0, ONES, ONES, 8'd255, 1'b1, 1'b0, 1'b0, ST_TOO_LONG),
			mk(CMD_INSERT, 1'b1, ONES, ONES, 8'd255, 1'b1, 1'b0, 1'b0, ST_TOO_LONG),
			// exact v4 address with junk above bit 31
			mk(CMD_INSERT, 1'b0, ONES, 64'hFFFF_FFFF_C0A8_0101, 8'd32, 1'b1, 1'b0, 1'b0, ST_OK),
			mk(CMD_LOOKUP, 1'b0, 64'h0, 64'hC0A8_0101, 8'd0, 1'b0, 1'b0, 1'b0, ST_OK),
			mk(CMD_LOOKUP, 1'b0, 64'h0, 64'hC0A8_0100, 8'd0, 1'b0, 1'b0, 1'b0, ST_OK),
			mk(CMD_INSERT, 1'b1, ONES, ONES, 8'd128, 1'b1, 1'b0, 1'b0, ST_OK),
			mk(CMD_LOOKUP, 1'b1, ONES, ONES, 8'd0, 1'b0, 1'b0, 1'b0, ST_OK),
			mk(CMD_LOOKUP, 1'b1, ONES, 64'hFFFF_FFFF_FFFF_FFFE, 8'd0, 1'b0, 1'b0, 1'b0, ST_OK),
			mk(CMD_INSERT, 1'b0, 64'h0, 64'h0A00_0000, 8'd8, 1'b1, 1'b0, 1'b0, ST_OK),
			mk(CMD_LOOKUP, 1'b0, 64'h0, 64'h0AFF_FFFF, 8'd0, 1'b0, 1'b0, 1'b0, ST_OK),
			// same bits as a v4 entry, but v6
			mk(CMD_LOOKUP, 1'b1, 64'h0, 64'h0AFF_FFFF, 8'd0, 1'b0, 1'b0, 1'b0, ST_OK),
			mk(CMD_INSERT, 1'b1, 64'h2001_0DB8_0000_0000, 64'h1234_5678_9ABC_DEF0, 8'd64,
				1'b1, 1'b0, 1'b0, ST_OK),
			mk(CMD_LOOKUP, 1'b1, 64'h2001_0DB8_0000_0000, 64'hFEDC_BA98_7654_3210, 8'd0,
				1'b0, 1'b0, 1'b0, ST_OK),
			mk(CMD_INSERT, 1'b1, 64'h0, 64'h8000_0000_0000_0000, 8'd65, 1'b1, 1'b0, 1'b0, ST_OK),
			mk(CMD_LOOKUP, 1'b1, 64'h0, 64'h8000_0000_0000_0001, 8'd0, 1'b0, 1'b0, 1'b0, ST_OK),
			mk(CMD_INSERT, 1'b0, 64'h0, 64'h0, 8'd1, 1'b1, 1'b0, 1'b0, ST_OK),
			mk(CMD_LOOKUP, 1'b0, 64'h0, 64'h7FFF_FFFF, 8'd0, 1'b0, 1'b0, 1'b0, ST_OK),
			// duplicate entry takes a slot of its own
			mk(CMD_INSERT, 1'b0, 64'h0, 64'hC0A8_0101, 8'd32, 1'b1, 1'b0, 1'b0, ST_OK),
			mk(CMD_LOOKUP, 1'b0, ONES, 64'hFFFF_FFFF_C0A8_0101, 8'hFF, 1'b0, 1'b0, 1'b0, ST_OK)
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == DENY_ROW)
				set_deny(1'b1);
			offer(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);
		end

		for (int ph = 0; ph < 3; ph++) begin
			set_deny(ph == 1);
			src_idle = (ph == 0) ? 28 : (ph == 1) ? 60 : 0;
			snk_idle = (ph == 0) ? 60 : (ph == 1) ? 28 : 0;
			// long receiver hold while items keep coming: the chain fills and stalls
			if (ph == 2)
				stall_reqs <= stall_reqs + 1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 0 && n == PHASE_ITEMS / 2)
					drain_results();
				it = rand_item(ph * PHASE_ITEMS + n);
				offer(it, 1'b0, '0);
			end
		end

		drain_results();
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (mismatches == 0 && decision_q.size() == 0)
			$display("ip_prefix_allow_deny_list_tb: clean");
		else
			$display("ip_prefix_allow_deny_list_tb: errors");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/ipadl_pkg.sv
rtl/core/ipadl_in_if.sv
rtl/core/ipadl_out_if.sv
rtl/core/ipadl_head.sv
rtl/core/ipadl_cell.sv
rtl/core/ip_prefix_allow_deny_list.sv
dv/ip_prefix_allow_deny_list_tb.sv
